>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the console core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tccb_pkg.sv
// ----------------------------------------------------------------------------
// tccb_pkg
// shared types and constants of the text console character buffer
// ----------------------------------------------------------------------------
package tccb_pkg;

	// default geometry limits
	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 128;

	// width of row counts and row indexes (set by the rows register)
	localparam int ROW_W = 6;

	// register reset values
	localparam logic [5:0] ROWS_RESET = 6'd24;
	localparam logic [7:0] COLS_RESET = 8'd80;

	// register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// opcodes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// control characters
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_FORMFEED  = 8'd12;

	// request payload
	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	// response payload
	typedef struct packed {
		logic [7:0] cell_char;
		logic [4:0] cursor_row_out;
		logic [7:0] cursor_col_out;
		logic       did_scroll;
	} rsp_t;

	// memory controls from the sequencer
	typedef struct packed {
		logic we_char;
		logic rd;
		logic we_len;
		logic clr_len;
	} mem_ctl_t;

	// cursor state after an item, carried down the pipeline
	typedef struct packed {
		logic [ROW_W-1:0] cur_row;
		logic [7:0]       cur_col;
		logic             scroll;
		logic             row_ok;
	} upd_t;

endpackage

>>> rtl/core/tccb_store.sv
// ----------------------------------------------------------------------------
// tccb_store
// character memory, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module tccb_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                 clk,
	input  tccb_pkg::mem_ctl_t   ctl,
	input  logic [AW-1:0]        addr,
	input  logic [7:0]           wdata,
	output logic [7:0]           rdata
);
	import tccb_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (ctl.we_char) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/tccb_rowlen.sv
// ----------------------------------------------------------------------------
// tccb_rowlen
// per-row length memory with valid bits, an invalid row reads as empty
// ----------------------------------------------------------------------------
module tccb_rowlen #(
	parameter int MAX_ROWS = 32,
	parameter int RW       = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tccb_pkg::mem_ctl_t ctl,
	input  logic [RW-1:0]      addr,
	input  logic [7:0]         wdata,
	output logic [7:0]         len
);
	import tccb_pkg::*;

	logic [7:0]          mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] vld_q;
	logic [7:0]          rd_q;
	logic                rv_q;

	// valid bits, cleared by reset, by a screen clear and by a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clr_len) begin
			vld_q <= '0;
		end else if (ctl.we_len) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// length write and registered read
	always_ff @(posedge clk) begin
		if (ctl.we_len) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rd_q <= mem[addr];
			rv_q <= vld_q[addr];
		end
	end

	assign len = rv_q ? rd_q : 8'd0;

endmodule

>>> rtl/core/tccb_ctrl.sv
// ----------------------------------------------------------------------------
// tccb_ctrl
// geometry registers, cursor and ring offset, memory access sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccb_ctrl #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128,
	parameter int AW       = 12,
	parameter int RW       = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               accept,
	input  tccb_pkg::req_t     req,
	output tccb_pkg::mem_ctl_t ctl,
	output logic [AW-1:0]      store_addr,
	output logic [RW-1:0]      len_addr,
	output logic [7:0]         len_wdata,
	output tccb_pkg::upd_t     upd
);
	import tccb_pkg::*;

	logic [5:0]       rows_reg_q;
	logic [7:0]       cols_reg_q;
	logic [ROW_W-1:0] top_q;
	logic [ROW_W-1:0] crow_q;
	logic [7:0]       ccol_q;

	logic [ROW_W-1:0] rows_eff;
	logic [7:0]       cols_eff;

	logic             is_read, is_bs, is_nl, is_ff;
	logic             wrap, last;
	logic [ROW_W-1:0] nl_row, nl_top;
	logic [ROW_W-1:0] put_row, put_top, put_phys, cur_phys, rd_phys;
	logic [7:0]       col_base;
	logic [ROW_W-1:0] row_sel;
	logic [7:0]       col_sel;
	logic [ROW_W-1:0] n_row, n_top;
	logic [7:0]       n_col;
	logic             n_scroll;

	// (a + b) mod n with a, b below n
	function automatic logic [ROW_W-1:0] ring_add(input logic [ROW_W-1:0] a,
			input logic [ROW_W-1:0] b, input logic [ROW_W-1:0] n);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[ROW_W-1:0];
	endfunction

	// clamped geometry
	always_comb begin
		if (rows_reg_q == 6'd0) begin
			rows_eff = 6'd1;
		end else if (rows_reg_q > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_reg_q;
		end
		if (cols_reg_q == 8'd0) begin
			cols_eff = 8'd1;
		end else if (cols_reg_q > MAX_COLS) begin
			cols_eff = 8'(MAX_COLS);
		end else begin
			cols_eff = cols_reg_q;
		end
	end

	// item decode
	assign is_read = (req.opcode == OP_READ);
	assign is_bs   = !is_read && (req.char_code == CH_BACKSPACE);
	assign is_nl   = !is_read && (req.char_code == CH_NEWLINE);
	assign is_ff   = !is_read && (req.char_code == CH_FORMFEED);

	// next line, scrolling at the bottom row
	assign last   = ({1'b0, crow_q} + 7'd1) >= {1'b0, rows_eff};
	assign nl_row = last ? (rows_eff - 6'd1) : (crow_q + 6'd1);
	assign nl_top = !last ? top_q :
		((top_q + 6'd1 == rows_eff) ? '0 : (top_q + 6'd1));

	// printable character with wrap
	assign wrap     = (ccol_q >= cols_eff);
	assign put_row  = wrap ? nl_row : crow_q;
	assign put_top  = wrap ? nl_top : top_q;
	assign col_base = wrap ? 8'd0 : ccol_q;
	assign put_phys = ring_add(put_top, put_row, rows_eff);
	assign cur_phys = ring_add(top_q, crow_q, rows_eff);
	assign rd_phys  = ring_add(top_q, {1'b0, req.read_row}, rows_eff);

	// next state and memory accesses
	always_comb begin
		n_row    = crow_q;
		n_col    = ccol_q;
		n_top    = top_q;
		n_scroll = 1'b0;
		ctl      = '0;
		row_sel  = put_phys;
		col_sel  = col_base;
		len_wdata = 8'd0;
		if (is_read) begin
			row_sel = rd_phys;
			col_sel = {1'b0, req.read_col};
			ctl.rd  = accept;
		end else if (is_bs) begin
			row_sel = cur_phys;
			if (ccol_q != 8'd0) begin
				n_col      = ccol_q - 8'd1;
				len_wdata  = ccol_q - 8'd1;
				ctl.we_len = accept;
			end
		end else if (is_nl) begin
			n_row    = nl_row;
			n_col    = 8'd0;
			n_top    = nl_top;
			n_scroll = last;
			// the old top row becomes the emptied bottom row
			row_sel    = top_q;
			ctl.we_len = accept && last;
		end else if (is_ff) begin
			n_row       = '0;
			n_col       = 8'd0;
			n_top       = '0;
			ctl.clr_len = accept;
		end else begin
			n_row       = put_row;
			n_top       = put_top;
			n_col       = col_base + 8'd1;
			n_scroll    = wrap && last;
			len_wdata   = col_base + 8'd1;
			ctl.we_char = accept;
			ctl.we_len  = accept;
		end
		if (cfg_we) begin
			ctl.clr_len = 1'b1;
		end
	end

	assign store_addr = AW'(row_sel) * AW'(MAX_COLS) + AW'(col_sel);
	assign len_addr   = RW'(row_sel);

	assign upd.cur_row = n_row;
	assign upd.cur_col = n_col;
	assign upd.scroll  = n_scroll;
	assign upd.row_ok  = ({1'b0, req.read_row} < rows_eff);

	// geometry, cursor and ring offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg_q <= ROWS_RESET;
			cols_reg_q <= COLS_RESET;
			top_q      <= '0;
			crow_q     <= '0;
			ccol_q     <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_reg_q <= cfg_data[5:0];
				REG_COLS: cols_reg_q <= cfg_data;
				default:  rows_reg_q <= rows_reg_q;
			endcase
			top_q  <= '0;
			crow_q <= '0;
			ccol_q <= 8'd0;
		end else if (accept) begin
			top_q  <= n_top;
			crow_q <= n_row;
			ccol_q <= n_col;
		end
	end

	// state stays inside the current geometry
	`ASSERT_ALWAYS(a_row_in_range, clk, arst_n, crow_q < rows_eff, "cursor row past last row")
	`ASSERT_ALWAYS(a_top_in_range, clk, arst_n, top_q < rows_eff, "ring offset past row count")
	`ASSERT_ALWAYS(a_col_in_range, clk, arst_n, ccol_q <= cols_eff, "cursor column past row end")
	// a scroll leaves the cursor on the bottom row
	`ASSERT_NEXT(a_scroll_bottom, clk, arst_n, accept && upd.scroll && !cfg_we, crow_q == $past(rows_eff) - 6'd1, "scroll left cursor off bottom row")

endmodule

>>> rtl/core/text_console_char_buffer_core.sv
// ----------------------------------------------------------------------------
// text_console_char_buffer_core
// text console character store with line wrap and ring scroll
// ----------------------------------------------------------------------------
//  channel  | direction | payload  | handshake
//  ---------+-----------+----------+---------------------------------
//  req      | in        | req_t    | req_valid / req_stall
//  rsp      | out       | rsp_t    | rsp_valid / rsp_stall
//  cfg      | in        | 8 bits   | cfg_we, cfg_index, no read-back
//
//  one item per cycle sustained while req_stall is low; a response passes
//  through the registered reads of the character and length memories and
//  then through the response register
//  reset clears the row length valid bits at once, no clearing pass
//  a stalled response holds the pipeline stage behind it, req_stall rises
//  only when both the read stage and the response register are full
// ----------------------------------------------------------------------------
module text_console_char_buffer_core #(
	parameter int MAX_ROWS = tccb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = tccb_pkg::MAX_COLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tccb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tccb_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data
);
	import tccb_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	mem_ctl_t      ctl;
	upd_t          upd;
	logic [AW-1:0] store_addr;
	logic [RW-1:0] len_addr;
	logic [7:0]    len_wdata;
	logic [7:0]    char_rd;
	logic [7:0]    len_rd;
	logic          accept, adv, hit;

	logic          s1_valid_s1;
	logic          s1_read_s1;
	logic [6:0]    s1_col_s1;
	upd_t          s1_upd_s1;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// handshake
	assign adv       = s1_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	tccb_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.AW       (AW),
		.RW       (RW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.req        (req),
		.ctl        (ctl),
		.store_addr (store_addr),
		.len_addr   (len_addr),
		.len_wdata  (len_wdata),
		.upd        (upd)
	);

	tccb_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.ctl   (ctl),
		.addr  (store_addr),
		.wdata (req.char_code),
		.rdata (char_rd)
	);

	tccb_rowlen #(
		.MAX_ROWS (MAX_ROWS),
		.RW       (RW)
	) u_rowlen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addr   (len_addr),
		.wdata  (len_wdata),
		.len    (len_rd)
	);

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_read_s1 <= (req.opcode == OP_READ) && upd.row_ok;
			s1_col_s1  <= req.read_col;
			s1_upd_s1  <= upd;
		end
	end

	// cell is valid only below the row length
	assign hit = s1_read_s1 && ({1'b0, s1_col_s1} < len_rd) && (s1_col_s1 < MAX_COLS);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.cell_char      <= hit ? char_rd : 8'd0;
			rsp_q.cursor_row_out <= s1_upd_s1.cur_row[4:0];
			rsp_q.cursor_col_out <= s1_upd_s1.cur_col;
			rsp_q.did_scroll     <= s1_upd_s1.scroll;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
